[sv/bssc_pkg.sv]
`timescale 1ns / 1ps

package bssc_pkg;

  localparam int GOAL_W      = 11;
  localparam int HIST_W      = 12;
  localparam int MATCH_W     = 20;
  localparam int QUEUE_DEPTH = 2;

  // how the back end finds the histogram count to add
  localparam logic [1:0] KIND_NONE = 2'd0;  // adds zero
  localparam logic [1:0] KIND_IMM  = 2'd1;  // count known in front, carried along
  localparam logic [1:0] KIND_MEM  = 2'd2;  // count comes from the histogram ram

  typedef struct packed {
    logic [1:0]        kind;
    logic [HIST_W-1:0] imm;
    logic              wr_en;
    logic [HIST_W-1:0] wr_data;
    logic              last;
    logic              over;
  } op_t;

endpackage

[sv/bssc_in_if.sv]
`timescale 1ns / 1ps

interface bssc_in_if;
  logic valid;
  logic ready;
  logic bit_value;
  logic is_last;

  modport source (output valid, output bit_value, output is_last, input ready);
  modport sink (input valid, input bit_value, input is_last, output ready);
endinterface

[sv/bssc_out_if.sv]
`timescale 1ns / 1ps

interface bssc_out_if;
  logic                        valid;
  logic                        ready;
  logic [bssc_pkg::MATCH_W-1:0] match_count;
  logic                        final_flag;
  logic                        too_long;

  modport source (output valid, output match_count, output final_flag, output too_long,
                  input ready);
  modport sink (input valid, input match_count, input final_flag, input too_long,
                output ready);
endinterface

[sv/bssc_ram.sv]
`timescale 1ns / 1ps

module bssc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1025,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/bssc_front.sv]
`timescale 1ns / 1ps

module bssc_front #(
  parameter int MAX_LEN = 1024,
  parameter int ADDR_W  = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  bssc_in_if.sink                     in,
  input  logic [bssc_pkg::GOAL_W-1:0] goal,
  input  logic                        full,
  output logic                        push,
  output bssc_pkg::op_t               op,
  output logic [ADDR_W-1:0]           rd_addr,
  output logic [ADDR_W-1:0]           wr_addr
);

  localparam int CMP_W = (ADDR_W > bssc_pkg::GOAL_W) ? ADDR_W : bssc_pkg::GOAL_W;

  logic [ADDR_W-1:0]               elem_count;
  logic [ADDR_W-1:0]               prefix;
  logic [bssc_pkg::HIST_W-1:0]     cur_count;  // histogram entry at the current prefix
  logic                            over;
  logic [ADDR_W-1:0]               prefix_new;
  logic [CMP_W-1:0]                diff;

  assign in.ready   = !full;
  assign push       = in.valid && !full;
  assign over       = (elem_count >= ADDR_W'(MAX_LEN));
  assign prefix_new = prefix + ADDR_W'(in.bit_value);
  assign diff       = CMP_W'(prefix_new) - CMP_W'(goal);

  always_comb begin
    op.kind    = bssc_pkg::KIND_NONE;
    op.imm     = cur_count;
    op.wr_en   = !over && in.bit_value;
    op.wr_data = cur_count;
    op.last    = in.is_last;
    op.over    = over;
    rd_addr    = diff[ADDR_W-1:0];
    wr_addr    = prefix;
    if (!over) begin
      if (goal == bssc_pkg::GOAL_W'(in.bit_value)) begin
        // lookup lands on the current prefix, whose count is held here
        op.kind = bssc_pkg::KIND_IMM;
      end else if (goal != '0 && CMP_W'(prefix_new) >= CMP_W'(goal)) begin
        // lookup lands below the current prefix, already written to the ram
        op.kind = bssc_pkg::KIND_MEM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
      prefix     <= '0;
      cur_count  <= bssc_pkg::HIST_W'(1);
    end else if (push) begin
      if (in.is_last) begin
        elem_count <= '0;
        prefix     <= '0;
        cur_count  <= bssc_pkg::HIST_W'(1);
      end else if (!over) begin
        elem_count <= elem_count + ADDR_W'(1);
        if (in.bit_value) begin
          prefix    <= prefix_new;
          cur_count <= bssc_pkg::HIST_W'(1);
        end else if (cur_count != '1) begin
          cur_count <= cur_count + bssc_pkg::HIST_W'(1);
        end
      end
    end
  end

endmodule

[sv/bssc_queue.sv]
`timescale 1ns / 1ps

module bssc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[sv/bssc_back.sv]
`timescale 1ns / 1ps

module bssc_back #(
  parameter int MAX_LEN = 1024,
  parameter int ADDR_W  = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  output logic              pop,
  input  bssc_pkg::op_t     op,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic [ADDR_W-1:0] wr_addr,
  bssc_out_if.source        out
);

  logic                          a_valid;
  bssc_pkg::op_t                 a_op;
  logic                          advance;
  logic                          load_a;
  logic [bssc_pkg::HIST_W-1:0]   rdata;
  logic [bssc_pkg::HIST_W-1:0]   add_val;
  logic [bssc_pkg::MATCH_W:0]    sum;
  logic [bssc_pkg::MATCH_W-1:0]  match_sat;
  logic [bssc_pkg::MATCH_W-1:0]  running;

  assign advance = !out.valid || out.ready;
  assign load_a  = !a_valid || advance;
  assign pop     = !empty && load_a;

  // the write at the old prefix and the read below it never share an address
  bssc_ram #(
    .WIDTH (bssc_pkg::HIST_W),
    .DEPTH (MAX_LEN + 1)
  ) u_hist (
    .clk   (clk),
    .we    (pop && op.wr_en),
    .waddr (wr_addr),
    .wdata (op.wr_data),
    .re    (pop),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_comb begin
    case (a_op.kind)
      bssc_pkg::KIND_IMM: add_val = a_op.imm;
      bssc_pkg::KIND_MEM: add_val = rdata;
      default:            add_val = '0;
    endcase
    sum       = {1'b0, running} + (bssc_pkg::MATCH_W + 1)'(add_val);
    match_sat = sum[bssc_pkg::MATCH_W] ? '1 : sum[bssc_pkg::MATCH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_op <= op;
    end
    if (a_valid && advance) begin
      out.match_count <= match_sat;
      out.final_flag  <= a_op.last;
      out.too_long    <= a_op.over;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out.valid <= 1'b0;
      running   <= '0;
    end else begin
      if (pop) begin
        a_valid <= 1'b1;
      end else if (advance) begin
        a_valid <= 1'b0;
      end
      if (a_valid && advance) begin
        out.valid <= 1'b1;
        running   <= a_op.last ? '0 : match_sat;
      end else if (out.ready) begin
        out.valid <= 1'b0;
      end
    end
  end

endmodule

[sv/binary_subarray_sum_counter_unit.sv]
`timescale 1ns / 1ps

// channel  | dir | payload                             | handshake
// ---------+-----+-------------------------------------+-------------------
// in       | in  | bit_value, is_last                  | valid/ready
// out      | out | match_count, final_flag, too_long   | valid/ready
// cfg      | in  | cfg_wdata (goal, 11 bit)            | cfg_we, no stall
//
// one item per cycle while out is not stalled; an item's result passes through a queue slot
// and the ram read, then is registered into the output reg before it is offered on out
// the single-port-write histogram ram takes at most one write and one read per item
// rst clears prefix, counts and queue at once; the ram needs no clearing since
// only entries below the current prefix, all rewritten in this sequence, are read
// a stall on out backs up through the two-entry queue to in.ready

module binary_subarray_sum_counter_unit #(
  parameter int MAX_LEN = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  bssc_in_if.sink                     in,
  bssc_out_if.source                  out,
  input  logic                        cfg_we,
  input  logic [bssc_pkg::GOAL_W-1:0] cfg_wdata
);

  localparam int ADDR_W = $clog2(MAX_LEN + 1);
  localparam int Q_W    = $bits(bssc_pkg::op_t) + 2 * ADDR_W;

  logic [bssc_pkg::GOAL_W-1:0] goal;
  logic                        push;
  logic                        pop;
  logic                        full;
  logic                        empty;
  bssc_pkg::op_t               f_op;
  bssc_pkg::op_t               b_op;
  logic [ADDR_W-1:0]           f_rd_addr;
  logic [ADDR_W-1:0]           f_wr_addr;
  logic [ADDR_W-1:0]           b_rd_addr;
  logic [ADDR_W-1:0]           b_wr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal <= '0;
    end else if (cfg_we) begin
      goal <= cfg_wdata;
    end
  end

  bssc_front #(
    .MAX_LEN (MAX_LEN),
    .ADDR_W  (ADDR_W)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in      (in),
    .goal    (goal),
    .full    (full),
    .push    (push),
    .op      (f_op),
    .rd_addr (f_rd_addr),
    .wr_addr (f_wr_addr)
  );

  bssc_queue #(
    .WIDTH (Q_W),
    .DEPTH (bssc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   ({f_op, f_rd_addr, f_wr_addr}),
    .pop   (pop),
    .dout  ({b_op, b_rd_addr, b_wr_addr}),
    .full  (full),
    .empty (empty)
  );

  bssc_back #(
    .MAX_LEN (MAX_LEN),
    .ADDR_W  (ADDR_W)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .empty   (empty),
    .pop     (pop),
    .op      (b_op),
    .rd_addr (b_rd_addr),
    .wr_addr (b_wr_addr),
    .out     (out)
  );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int SEQ_MAX   = 1024;
  localparam int MATCH_TOP = (1 << bssc_pkg::MATCH_W) - 1;
  localparam int HIST_TOP  = (1 << bssc_pkg::HIST_W) - 1;
  localparam int HOLD_LEN  = 300;

  typedef struct packed {
    logic bit_value;
    logic is_last;
  } bit_item_t;

  typedef struct packed {
    logic [bssc_pkg::MATCH_W-1:0] match_count;
    logic                         final_flag;
    logic                         too_long;
  } tally_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [bssc_pkg::GOAL_W-1:0] cfg_wdata;

  bssc_in_if  in_ch ();
  bssc_out_if out_ch ();

  binary_subarray_sum_counter_unit #(.MAX_LEN(SEQ_MAX)) dut (
    .clk       (clk),
    .rst       (rst),
    .in        (in_ch),
    .out       (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [bssc_pkg::GOAL_W-1:0] goal_reg;
  int unsigned                 prefix_sum;
  int unsigned                 bits_taken;
  int unsigned                 match_total;
  int unsigned                 prefix_seen [0:SEQ_MAX];

  bit_item_t pending_bits [$];
  tally_t    expected_tallies [$];

  int errors     = 0;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_req   = 0;
  int hold_ack   = 0;
  int hold_left  = 0;
  int seq_left   = 0;
  int ones_pct   = 50;

  always #2 clk = ~clk;

  function automatic void restart_sequence();
    prefix_sum  = 0;
    bits_taken  = 0;
    match_total = 0;
    foreach (prefix_seen[i]) prefix_seen[i] = 0;
    prefix_seen[0] = 1;
  endfunction

  function automatic tally_t score_bit(logic b, logic last);
    tally_t      t;
    int unsigned slot;
    int unsigned sum;
    t.too_long = 1'b0;
    if (bits_taken >= SEQ_MAX) begin
      t.too_long = 1'b1;
    end else begin
      bits_taken++;
      prefix_sum += b;
      if (prefix_sum >= goal_reg) begin
        slot = prefix_sum - goal_reg;
        if (slot <= SEQ_MAX) begin
          sum = match_total + prefix_seen[slot];
          match_total = (sum > MATCH_TOP) ? MATCH_TOP : sum;
        end
      end
      if (prefix_sum <= SEQ_MAX && prefix_seen[prefix_sum] < HIST_TOP)
        prefix_seen[prefix_sum]++;
    end
    t.match_count = match_total[bssc_pkg::MATCH_W-1:0];
    t.final_flag  = last;
    if (last) restart_sequence();
    return t;
  endfunction

  // driver
  always @(posedge clk) begin : drive_proc
    logic stuck;
    if (rst) begin
      in_ch.valid     <= 1'b0;
      in_ch.bit_value <= 1'b0;
      in_ch.is_last   <= 1'b0;
    end else begin
      stuck = in_ch.valid && !in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        expected_tallies.push_back(score_bit(in_ch.bit_value, in_ch.is_last));
        void'(pending_bits.pop_front());
      end
      if (!stuck) begin
        if (pending_bits.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_ch.valid     <= 1'b1;
          in_ch.bit_value <= pending_bits[0].bit_value;
          in_ch.is_last   <= pending_bits[0].is_last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with random stalls and a single long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      out_ch.ready <= 1'b0;
      hold_ack     <= hold_req;
      hold_left    <= HOLD_LEN;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin : check_proc
    tally_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_tallies.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, got count %0d final %0b too_long %0b",
                 $time, out_ch.match_count, out_ch.final_flag, out_ch.too_long);
      end else begin
        want = expected_tallies.pop_front();
        if (out_ch.match_count !== want.match_count) begin
          errors++;
          $display("%0t: match_count expected %0d got %0d",
                   $time, want.match_count, out_ch.match_count);
        end
        if (out_ch.final_flag !== want.final_flag) begin
          errors++;
          $display("%0t: final_flag expected %0b got %0b",
                   $time, want.final_flag, out_ch.final_flag);
        end
        if (out_ch.too_long !== want.too_long) begin
          errors++;
          $display("%0t: too_long expected %0b got %0b",
                   $time, want.too_long, out_ch.too_long);
        end
      end
    end
  end

  task automatic add_item(logic b, logic last);
    bit_item_t it;
    it.bit_value = b;
    it.is_last   = last;
    pending_bits.push_back(it);
  endtask

  task automatic write_goal(logic [bssc_pkg::GOAL_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    goal_reg = v;
  endtask

  task automatic wait_drain();
    while (pending_bits.size() != 0 || expected_tallies.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 56; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 56; end
      default: begin idle_pct = 32; stall_pct = 32; end
    endcase
  endtask

  // random sequences; a sequence may stay open across a phase boundary
  task automatic queue_random(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      if (seq_left == 0) begin
        r = $urandom_range(99);
        if (r < 80) seq_left = $urandom_range(12, 1);
        else if (r < 95) seq_left = $urandom_range(60, 13);
        else seq_left = $urandom_range(200, 61);
        case ($urandom_range(5))
          0: ones_pct = 0;
          1: ones_pct = 100;
          2: ones_pct = 25;
          3: ones_pct = 75;
          default: ones_pct = $urandom_range(100);
        endcase
      end
      add_item($urandom_range(99) < ones_pct, seq_left == 1);
      seq_left--;
    end
  endtask

  task automatic queue_run(int len, int pct);
    for (int k = 1; k <= len; k++) add_item($urandom_range(99) < pct, k == len);
  endtask

  initial begin : stimulus
    logic [bssc_pkg::GOAL_W-1:0] goals [8];
    clk             = 1'b0;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.bit_value = 1'b0;
    in_ch.is_last   = 1'b0;
    out_ch.ready    = 1'b0;
    goal_reg        = '0;
    restart_sequence();
    goals = '{11'd1, 11'd2, 11'd0, 11'd3, 11'd1024, 11'd5, 11'd2047, 11'd1};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: goal at reset value zero
    set_idling(0);
    add_item(1'b0, 1'b1);
    add_item(1'b1, 1'b1);
    add_item(1'b0, 1'b0);
    add_item(1'b0, 1'b0);
    add_item(1'b1, 1'b0);
    add_item(1'b0, 1'b1);
    wait_drain();
    write_goal(11'd1);
    add_item(1'b1, 1'b1);
    add_item(1'b0, 1'b1);
    add_item(1'b1, 1'b0);
    add_item(1'b0, 1'b0);
    add_item(1'b1, 1'b0);
    add_item(1'b1, 1'b1);
    wait_drain();
    // goal above the prefix reached
    write_goal(11'd3);
    add_item(1'b1, 1'b0);
    add_item(1'b1, 1'b1);
    wait_drain();
    write_goal(11'd2047);
    add_item(1'b1, 1'b0);
    add_item(1'b1, 1'b1);
    wait_drain();

    // full-length run of zeros, then items past the length limit
    write_goal(11'd0);
    queue_run(SEQ_MAX + 2, 0);
    wait_drain();

    // random phases; goal changes land inside open sequences
    for (int p = 0; p < 8; p++) begin
      write_goal(p == 7 ? 11'($urandom_range(8)) : goals[p]);
      set_idling(p);
      queue_random(75);
      if (p == 4) hold_req++;
      wait_drain();
    end
    if (seq_left > 0) begin
      queue_random(seq_left);
      wait_drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("binary_subarray_sum_counter_unit verification clean");
    end else begin
      $display("binary_subarray_sum_counter_unit verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("binary_subarray_sum_counter_unit verification failed");
    $finish;
  end

endmodule

[files.f]
sv/bssc_pkg.sv
sv/bssc_in_if.sv
sv/bssc_out_if.sv
sv/bssc_ram.sv
sv/bssc_front.sv
sv/bssc_queue.sv
sv/bssc_back.sv
sv/binary_subarray_sum_counter_unit.sv
verif/tb_top.sv
